>>> sv/bpm_pkg.sv
package bpm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 7;
    localparam int MODE_W      = 3;
    localparam int ST_W        = 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SWAP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LK_HW = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LK_PR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_MAPPED   = 2'd2;
    localparam logic [ST_W-1:0] ST_UNMAPPED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROG_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HW_COUNT   = 1'b1;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_ENTRIES);

endpackage

>>> sv/bpm_ram.sv
module bpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/bidirectional_permutation_map_core.sv
// add, clear, unused modes, rejected requests, self-swaps: o_done in the next cycle, busy stays low
// lookups pass S_LOOK, swaps S_SW_A, S_SW_B and S_SW_C; busy in these states, o_done after the last
// requests are taken only while not busy, set by the single read and write port of each table memory
// a swap reads the hardware table twice and writes each table twice
// reset clears all valid bits at once and sets both counts to 64; no clearing pass is needed
// results are shown for one cycle on o_done and cannot be held off by the receiver
module bidirectional_permutation_map_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpm_pkg::CNT_W-1:0]      i_cfg_wdata,
    input  logic [bpm_pkg::MODE_W-1:0]     i_mode,
    input  logic [bpm_pkg::IDX_W-1:0]      i_prog_index,
    input  logic [bpm_pkg::IDX_W-1:0]      i_hw_index,
    input  logic [bpm_pkg::IDX_W-1:0]      i_hw_index_b,
    output logic                           o_done,
    output logic [bpm_pkg::IDX_W-1:0]      o_found_index,
    output logic                           o_is_mapped,
    output logic [bpm_pkg::ST_W-1:0]       o_status
);

    import bpm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SW_A,
        S_SW_B,
        S_SW_C
    } t_state;

    t_state                 r_state;
    t_state                 w_go;
    logic [CNT_W-1:0]       r_prog_count;
    logic [CNT_W-1:0]       r_hw_count;
    logic [MAX_ENTRIES-1:0] r_prog_valid;
    logic [MAX_ENTRIES-1:0] r_hw_valid;
    logic [IDX_W-1:0]       r_ha;
    logic [IDX_W-1:0]       r_hb;
    logic [IDX_W-1:0]       r_pa;
    logic                   r_lk_hw;

    logic [CNT_W-1:0]       w_np;
    logic [CNT_W-1:0]       w_nh;
    logic                   w_p_oor;
    logic                   w_a_oor;
    logic                   w_b_oor;
    logic                   w_accept;
    logic                   w_add;
    logic                   w_clr;
    logic [ST_W-1:0]        w_res_status;

    logic                   w_p2h_we;
    logic [IDX_W-1:0]       w_p2h_waddr;
    logic [IDX_W-1:0]       w_p2h_wdata;
    logic [IDX_W-1:0]       w_p2h_rdata;
    logic                   w_h2p_we;
    logic [IDX_W-1:0]       w_h2p_waddr;
    logic [IDX_W-1:0]       w_h2p_wdata;
    logic [IDX_W-1:0]       w_h2p_raddr;
    logic [IDX_W-1:0]       w_h2p_rdata;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_np = (r_prog_count > COUNT_RESET) ? COUNT_RESET : r_prog_count;
    assign w_nh = (r_hw_count > COUNT_RESET) ? COUNT_RESET : r_hw_count;

    assign w_p_oor = CNT_W'(i_prog_index) >= w_np;
    assign w_a_oor = CNT_W'(i_hw_index) >= w_nh;
    assign w_b_oor = CNT_W'(i_hw_index_b) >= w_nh;

    // request decode, range checks against the counts and checks against the valid bits
    always_comb begin
        w_res_status = ST_OK;
        w_go         = S_IDLE;
        w_add        = 1'b0;
        w_clr        = 1'b0;
        case (i_mode)
            MODE_ADD: begin
                if (w_p_oor || w_a_oor) begin
                    w_res_status = ST_RANGE;
                end else if (r_prog_valid[i_prog_index] || r_hw_valid[i_hw_index]) begin
                    w_res_status = ST_MAPPED;
                end else begin
                    w_add = 1'b1;
                end
            end
            MODE_SWAP: begin
                if (w_a_oor || w_b_oor) begin
                    w_res_status = ST_RANGE;
                end else if (i_hw_index == i_hw_index_b) begin
                    w_res_status = ST_OK;
                end else if (!r_hw_valid[i_hw_index] || !r_hw_valid[i_hw_index_b]) begin
                    w_res_status = ST_UNMAPPED;
                end else begin
                    w_go = S_SW_A;
                end
            end
            MODE_LK_HW: begin
                if (w_a_oor) begin
                    w_res_status = ST_RANGE;
                end else if (!r_hw_valid[i_hw_index]) begin
                    w_res_status = ST_UNMAPPED;
                end else begin
                    w_go = S_LOOK;
                end
            end
            MODE_LK_PR: begin
                if (w_p_oor) begin
                    w_res_status = ST_RANGE;
                end else if (!r_prog_valid[i_prog_index]) begin
                    w_res_status = ST_UNMAPPED;
                end else begin
                    w_go = S_LOOK;
                end
            end
            MODE_CLEAR: begin
                w_clr = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // memory ports; a request is only taken once all writes of the previous one are done
    always_comb begin
        w_h2p_raddr = (r_state == S_SW_A) ? r_hb : i_hw_index;
        case (r_state)
            S_SW_B: begin
                w_h2p_we    = 1'b1;
                w_h2p_waddr = r_ha;
                w_h2p_wdata = w_h2p_rdata;
                w_p2h_we    = 1'b1;
                w_p2h_waddr = w_h2p_rdata;
                w_p2h_wdata = r_ha;
            end
            S_SW_C: begin
                w_h2p_we    = 1'b1;
                w_h2p_waddr = r_hb;
                w_h2p_wdata = r_pa;
                w_p2h_we    = 1'b1;
                w_p2h_waddr = r_pa;
                w_p2h_wdata = r_hb;
            end
            default: begin
                w_h2p_we    = w_accept && w_add;
                w_h2p_waddr = i_hw_index;
                w_h2p_wdata = i_prog_index;
                w_p2h_we    = w_accept && w_add;
                w_p2h_waddr = i_prog_index;
                w_p2h_wdata = i_hw_index;
            end
        endcase
    end

    bpm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_p2h_ram (
        .i_clk   (i_clk),
        .i_we    (w_p2h_we),
        .i_waddr (w_p2h_waddr),
        .i_wdata (w_p2h_wdata),
        .i_raddr (i_prog_index),
        .o_rdata (w_p2h_rdata)
    );

    bpm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTRIES)
    ) u_h2p_ram (
        .i_clk   (i_clk),
        .i_we    (w_h2p_we),
        .i_waddr (w_h2p_waddr),
        .i_wdata (w_h2p_wdata),
        .i_raddr (w_h2p_raddr),
        .o_rdata (w_h2p_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prog_count  <= COUNT_RESET;
            r_hw_count    <= COUNT_RESET;
            r_prog_valid  <= '0;
            r_hw_valid    <= '0;
            r_ha          <= '0;
            r_hb          <= '0;
            r_pa          <= '0;
            r_lk_hw       <= 1'b0;
            o_done        <= 1'b0;
            o_found_index <= '0;
            o_is_mapped   <= 1'b0;
            o_status      <= ST_OK;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROG_COUNT: r_prog_count <= i_cfg_wdata;
                    CFG_HW_COUNT:   r_hw_count   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ha    <= i_hw_index;
                        r_hb    <= i_hw_index_b;
                        r_lk_hw <= (i_mode == MODE_LK_HW);
                        r_state <= w_go;
                        if (w_go == S_IDLE) begin
                            o_done        <= 1'b1;
                            o_found_index <= '0;
                            o_is_mapped   <= 1'b0;
                            o_status      <= w_res_status;
                        end
                        if (w_add) begin
                            r_prog_valid[i_prog_index] <= 1'b1;
                            r_hw_valid[i_hw_index]     <= 1'b1;
                        end
                        if (w_clr) begin
                            r_prog_valid <= '0;
                            r_hw_valid   <= '0;
                        end
                    end
                end
                S_LOOK: begin
                    o_done        <= 1'b1;
                    o_found_index <= r_lk_hw ? w_h2p_rdata : w_p2h_rdata;
                    o_is_mapped   <= 1'b1;
                    o_status      <= ST_OK;
                    r_state       <= S_IDLE;
                end
                S_SW_A: begin
                    r_pa    <= w_h2p_rdata;
                    r_state <= S_SW_B;
                end
                S_SW_B: begin
                    r_prog_valid[w_h2p_rdata] <= 1'b1;
                    r_state                   <= S_SW_C;
                end
                S_SW_C: begin
                    r_prog_valid[r_pa] <= 1'b1;
                    o_done             <= 1'b1;
                    o_found_index      <= '0;
                    o_is_mapped        <= 1'b0;
                    o_status           <= ST_OK;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_valid_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_prog_valid) == $countones(r_hw_valid))
        else $error("program and hardware valid counts differ");

    a_add_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_add) |=>
        (r_prog_valid[$past(i_prog_index)] && r_hw_valid[$past(i_hw_index)]))
        else $error("add did not set both valid bits");

    a_swap_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_A) |=> (r_state == S_SW_B) ##1 (r_state == S_SW_C) ##1 o_done)
        else $error("swap sequence broken");

    a_lookup_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (o_done && o_is_mapped && r_state == S_IDLE))
        else $error("lookup result missing");

    a_mapped_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_mapped) |-> (o_status == ST_OK))
        else $error("mapped result without ok status");

endmodule
